FILE: hw/rtl/lsp_pkg.sv
// lsp_pkg: shared types and constants for the led strip pulse width serializer
// payload structs, phase encoding, register indexes and reset values
// no dependencies
package lsp_pkg;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic        line_level;
      logic        byte_taken;
      logic        busy_res;
      logic        frame_done;
      logic [31:0] emit_ticks;
      logic [19:0] latch_ticks;
      logic [15:0] min_rise_interval;
      logic [15:0] max_rise_interval;
   } rsp_type;

   typedef struct packed {
      logic [11:0] zero_high_cycles;
      logic [11:0] one_high_cycles;
      logic [11:0] bit_period_cycles;
      logic [19:0] latch_low_cycles;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_RESET    = 3'd1,
      PH_HIGH     = 3'd2,
      PH_LOWBIT   = 3'd3,
      PH_WAITBYTE = 3'd4,
      PH_TAIL     = 3'd5,
      PH_LATCH    = 3'd6
   } phase_type;

   localparam logic [1:0] CSR_ZERO_HIGH  = 2'd0;
   localparam logic [1:0] CSR_ONE_HIGH   = 2'd1;
   localparam logic [1:0] CSR_BIT_PERIOD = 2'd2;
   localparam logic [1:0] CSR_LATCH_LOW  = 2'd3;

   localparam logic [11:0] ZERO_HIGH_RESET  = 12'd40;
   localparam logic [11:0] ONE_HIGH_RESET   = 12'd80;
   localparam logic [11:0] BIT_PERIOD_RESET = 12'd125;
   localparam logic [19:0] LATCH_LOW_RESET  = 20'd28000;

   localparam logic [2:0]  MSB_POS   = 3'd7;
   localparam logic [15:0] SINCE_MAX = 16'hFFFF;
   localparam logic [31:0] EMIT_MAX  = 32'hFFFF_FFFF;

endpackage

FILE: hw/rtl/lsp_front.sv
// lsp_front: input side, takes ticks off the request channel into a short queue
// depends on lsp_pkg for the request payload type
module lsp_front
   import lsp_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    pop,
   output logic    q_valid,
   output req_type q_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   req_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;

   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

FILE: hw/rtl/lsp_engine.sv
// lsp_engine: back part, runs the line phase machine one tick per step
// depends on lsp_pkg for payload, config and phase types
module lsp_engine
   import lsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   phase_type   phase_ff, phase_in;
   logic [19:0] pc_ff, pc_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  pos_ff, pos_in;
   logic        final_ff, final_in;
   logic [15:0] since_ff, since_in;
   logic        seen_ff, seen_in;
   logic [15:0] imin_ff, imin_in;
   logic [15:0] imax_ff, imax_in;
   logic [31:0] emit_ff, emit_in;

   logic        in_wait;
   logic [7:0]  bit_byte;
   logic [2:0]  bit_pos;
   logic        bit_final;
   logic [11:0] bit_high_len;
   logic        elapsed;
   logic [15:0] since_inc;
   logic [31:0] emit_inc;
   phase_type   ah_phase;
   logic [2:0]  ah_pos;
   logic [20:0] pc_next;
   logic [20:0] latch_cnt;
   logic        do_rise;
   logic        do_low;
   logic        latch_go;

   // bit under way: a byte arriving in byte wait rises with its top bit
   assign in_wait   = (phase_ff == PH_WAITBYTE);
   assign bit_byte  = in_wait ? item.data_byte : shift_ff;
   assign bit_pos   = in_wait ? MSB_POS : pos_ff;
   assign bit_final = in_wait ? item.frame_last : final_ff;
   assign bit_high_len = bit_byte[bit_pos] ? cfg.one_high_cycles : cfg.zero_high_cycles;
   assign elapsed   = !seen_ff || (since_ff >= {4'b0, cfg.bit_period_cycles});
   assign since_inc = (since_ff == SINCE_MAX) ? since_ff : since_ff + 16'd1;
   assign emit_inc  = (emit_ff == EMIT_MAX) ? emit_ff : emit_ff + 32'd1;
   assign pc_next   = {1'b0, pc_ff} + 21'd1;

   // where the phase goes once the high time of the current bit is over
   always_comb begin
      if (bit_pos != '0) begin
         ah_phase = PH_LOWBIT;
         ah_pos   = bit_pos - 3'd1;
      end else begin
         ah_phase = bit_final ? PH_TAIL : PH_WAITBYTE;
         ah_pos   = bit_pos;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pc_in     = pc_ff;
      shift_in  = shift_ff;
      pos_in    = pos_ff;
      final_in  = final_ff;
      since_in  = since_ff;
      seen_in   = seen_ff;
      imin_in   = imin_ff;
      imax_in   = imax_ff;
      emit_in   = emit_ff;
      result    = '0;
      do_rise   = 1'b0;
      do_low    = 1'b0;
      latch_go  = 1'b0;
      latch_cnt = '0;
      result.busy_res = 1'b1;

      case (phase_ff)
         PH_RESET: begin
            if (pc_next >= {1'b0, cfg.latch_low_cycles}) begin
               pc_in    = '0;
               phase_in = PH_LOWBIT;
            end else begin
               pc_in = pc_next[19:0];
            end
         end
         PH_HIGH: begin
            result.line_level = 1'b1;
            emit_in  = emit_inc;
            since_in = since_inc;
            pc_in    = pc_next[19:0];
            if (pc_next >= {9'b0, bit_high_len}) begin
               phase_in = ah_phase;
               pos_in   = ah_pos;
            end
         end
         PH_LOWBIT: begin
            do_rise = elapsed;
            do_low  = !elapsed;
         end
         PH_WAITBYTE: begin
            if (item.byte_valid) begin
               result.byte_taken = 1'b1;
               shift_in = item.data_byte;
               final_in = item.frame_last;
               pos_in   = MSB_POS;
               phase_in = PH_LOWBIT;
            end
            do_rise = item.byte_valid && elapsed;
            do_low  = !(item.byte_valid && elapsed);
         end
         PH_TAIL: begin
            if (elapsed) begin
               phase_in = PH_LATCH;
               latch_go = 1'b1;
            end else begin
               do_low = 1'b1;
            end
         end
         PH_LATCH: begin
            latch_go = 1'b1;
         end
         default: begin
            // idle, and any unused code behaves as idle
            result.busy_res = 1'b0;
            if (item.byte_valid) begin
               result.byte_taken = 1'b1;
               shift_in = item.data_byte;
               final_in = item.frame_last;
               pos_in   = MSB_POS;
               seen_in  = 1'b0;
               since_in = '0;
               imin_in  = SINCE_MAX;
               imax_in  = '0;
               emit_in  = '0;
               pc_in    = '0;
               phase_in = PH_RESET;
            end
         end
      endcase

      if (do_low) begin
         since_in = since_inc;
         emit_in  = emit_inc;
      end

      if (do_rise) begin
         result.line_level = 1'b1;
         if (seen_ff) begin
            if (since_ff < imin_ff) imin_in = since_ff;
            if (since_ff > imax_ff) imax_in = since_ff;
         end
         seen_in  = 1'b1;
         since_in = 16'd1;
         emit_in  = emit_inc;
         pc_in    = 20'd1;
         phase_in = PH_HIGH;
         if (bit_high_len <= 12'd1) begin
            phase_in = ah_phase;
            pos_in   = ah_pos;
         end
      end

      if (latch_go) begin
         // the tick that leaves the tail already counts as a latch tick
         latch_cnt = (phase_ff == PH_LATCH) ? pc_next : 21'd1;
         if (latch_cnt >= {1'b0, cfg.latch_low_cycles}) begin
            result.frame_done        = 1'b1;
            result.emit_ticks        = emit_ff;
            result.latch_ticks       = latch_cnt[19:0];
            result.min_rise_interval = imin_ff;
            result.max_rise_interval = imax_ff;
            pc_in    = '0;
            phase_in = PH_IDLE;
         end else begin
            pc_in = latch_cnt[19:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pc_ff    <= '0;
         shift_ff <= '0;
         pos_ff   <= MSB_POS;
         final_ff <= 1'b0;
         since_ff <= '0;
         seen_ff  <= 1'b0;
         imin_ff  <= SINCE_MAX;
         imax_ff  <= '0;
         emit_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         shift_ff <= shift_in;
         pos_ff   <= pos_in;
         final_ff <= final_in;
         since_ff <= since_in;
         seen_ff  <= seen_in;
         imin_ff  <= imin_in;
         imax_ff  <= imax_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

FILE: hw/rtl/led_strip_pulse_width_serializer_core.sv
// led_strip_pulse_width_serializer_core: top level of the pulse width serializer
// holds the timing registers and output register; uses lsp_pkg, lsp_front, lsp_engine
//
//   channel   ports                              direction  moves
//   request   req_valid req_stall req_data       in         one clock tick of byte offer
//   response  rsp_valid rsp_stall rsp_data       out        line level and frame status
//   csr       csr_valid csr_ready csr_index ...  in         timing register write
//
// one tick is taken and one result produced every cycle while neither side stalls
// a result is offered once its tick has passed the queue slot and then the result
// register; the request queue (QUEUE_DEPTH entries) keeps both sides apart
// the phase machine advances only when a result can be written, so a stalled
// response fills the queue and then raises req_stall
// synchronous reset clears the queue, the phase state and restores register defaults
module led_strip_pulse_width_serializer_core
   import lsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    q_valid;
   req_type q_item;
   logic    step;
   rsp_type result;

   assign csr_ready = 1'b1;
   assign step      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_high_cycles  <= ZERO_HIGH_RESET;
         cfg_ff.one_high_cycles   <= ONE_HIGH_RESET;
         cfg_ff.bit_period_cycles <= BIT_PERIOD_RESET;
         cfg_ff.latch_low_cycles  <= LATCH_LOW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_HIGH:  cfg_ff.zero_high_cycles  <= csr_wdata[11:0];
            CSR_ONE_HIGH:   cfg_ff.one_high_cycles   <= csr_wdata[11:0];
            CSR_BIT_PERIOD: cfg_ff.bit_period_cycles <= csr_wdata[11:0];
            CSR_LATCH_LOW:  cfg_ff.latch_low_cycles  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lsp_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .pop       (step),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   lsp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (q_item),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result register: refilled on each step, emptied by a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

endmodule
